>>> sv/five_tuple_packet_filter_top_defines.svh
// ---------------------------------------------------------------------------
// Five-tuple packet filter assertion macros
// Clocked, reset-qualified property shorthands for the checker.
// ---------------------------------------------------------------------------
`ifndef FIVE_TUPLE_PACKET_FILTER_TOP_DEFINES_SVH
`define FIVE_TUPLE_PACKET_FILTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FTPF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("five_tuple_packet_filter: property violated");

// next-cycle implication
`define FTPF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("five_tuple_packet_filter: property violated");

`endif

>>> sv/ftpf_pkg.sv
// ---------------------------------------------------------------------------
// Five-tuple packet filter package
// Shared constants, codes and types of the filter.
// ---------------------------------------------------------------------------
package ftpf_pkg;

	localparam int PORT_ENTRIES = 8;
	localparam logic [15:0] IPV4_ETHERTYPE = 16'd2048;

	// item operations
	localparam logic [1:0] OP_CLASSIFY  = 2'd0;
	localparam logic [1:0] OP_WRITE_SRC = 2'd1;
	localparam logic [1:0] OP_WRITE_DST = 2'd2;

	// verdict reasons
	localparam logic [2:0] REASON_PASS  = 3'd0;
	localparam logic [2:0] REASON_L3    = 3'd1;
	localparam logic [2:0] REASON_SRC   = 3'd2;
	localparam logic [2:0] REASON_DST   = 3'd3;
	localparam logic [2:0] REASON_L4    = 3'd4;
	localparam logic [2:0] REASON_SPORT = 3'd5;
	localparam logic [2:0] REASON_DPORT = 3'd6;
	localparam logic [2:0] REASON_TABLE = 3'd7;

	// condition numbers; mode bit 2k enables, 2k+1 negates
	localparam int COND_L3    = 0;
	localparam int COND_SRC   = 1;
	localparam int COND_DST   = 2;
	localparam int COND_L4    = 3;
	localparam int COND_SPORT = 4;
	localparam int COND_DPORT = 5;
	localparam int NUM_CONDS  = 6;

	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ETHERTYPE   = 4'd0,
		REG_L4_PROTOCOL = 4'd1,
		REG_SRC_VALUE   = 4'd2,
		REG_SRC_MASK    = 4'd3,
		REG_DST_VALUE   = 4'd4,
		REG_DST_MASK    = 4'd5,
		REG_MODES       = 4'd6,
		REG_COUNTS      = 4'd7
	} cfg_reg_t;

	// one port table write
	typedef struct packed {
		logic        en;
		logic [2:0]  idx;
		logic [15:0] port;
	} port_wr_t;

	// saturate a raw 4-bit entry count at the table depth
	function automatic logic [3:0] sat_count(input logic [3:0] raw);
		logic [3:0] res;
		if (32'(raw) > PORT_ENTRIES) begin
			res = 4'(PORT_ENTRIES);
		end else begin
			res = raw;
		end
		return res;
	endfunction

endpackage

>>> sv/ftpf_port_list.sv
// ---------------------------------------------------------------------------
// Port list
// One port table with its write port and a registered list-membership match.
// ---------------------------------------------------------------------------
module ftpf_port_list (
	input  logic              clk,
	input  ftpf_pkg::port_wr_t wr,
	input  logic              advance,
	input  logic [15:0]       port,
	input  logic [3:0]        count,
	output logic              match_s2
);
	import ftpf_pkg::*;

	logic [15:0] table_q [PORT_ENTRIES];
	logic [PORT_ENTRIES-1:0] hit;

	// entries carry no reset: the user must write an entry before it is read; not enforced here
	always_ff @(posedge clk) begin
		for (int e = 0; e < PORT_ENTRIES; e++) begin
			if (wr.en && 32'(wr.idx) == e) begin
				table_q[e] <= wr.port;
			end
		end
	end

	always_comb begin
		for (int e = 0; e < PORT_ENTRIES; e++) begin
			hit[e] = (32'(count) > e) && (table_q[e] == port);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			match_s2 <= |hit;
		end
	end

endmodule

>>> sv/five_tuple_packet_filter_top.sv
// ---------------------------------------------------------------------------
// Five-tuple packet filter
// Checks ethertype, masked addresses, L4 protocol and port lists of each
// packet and gives a pass verdict with the first failing condition.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  operation .. entry_port
//  out      out_valid/ out_stall pass, verdict_reason
//  cfg      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// Three register stages: input capture, compares and list match, verdict.
// One item per cycle while no stalled output holds the pipeline.
// Port table writes take effect at the accept edge, in item order.
// A stalled output holds the whole pipeline and raises in_stall.
// Reset clears config registers and valid bits; no clearing pass.
// ---------------------------------------------------------------------------
module five_tuple_packet_filter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [15:0] ethertype,
	input  logic [31:0] source_ip,
	input  logic [31:0] dest_ip,
	input  logic [7:0]  ip_protocol,
	input  logic        is_tcp_or_udp,
	input  logic [15:0] source_port,
	input  logic [15:0] dest_port,
	input  logic [2:0]  entry_index,
	input  logic [15:0] entry_port,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pass,
	output logic [2:0]  verdict_reason,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [ftpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import ftpf_pkg::*;

	logic [15:0] ethertype_value_q;
	logic [7:0]  l4_protocol_value_q;
	logic [31:0] src_value_q, src_mask_q, dst_value_q, dst_mask_q;
	logic [11:0] modes_q;
	logic [7:0]  counts_q;

	logic        advance, in_accept;
	port_wr_t    src_wr, dst_wr;

	logic        valid_s1, valid_s2, valid_s3;
	logic [1:0]  op_s1, op_s2;
	logic [15:0] etype_s1;
	logic [31:0] sip_s1, dip_s1;
	logic [7:0]  proto_s1;
	logic        tcp_udp_s1, tcp_udp_s2;
	logic [15:0] sport_s1, dport_s1;
	logic        ipv4_s2;
	logic        l3_match_s2, src_match_s2, dst_match_s2, l4_match_s2;
	logic        sport_match_s2, dport_match_s2;
	logic [NUM_CONDS-1:0] match_s2, en, neg, fail;
	logic [2:0]  reason;
	logic        pass_s3;
	logic [2:0]  reason_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ethertype_value_q   <= '0;
			l4_protocol_value_q <= '0;
			src_value_q         <= '0;
			src_mask_q          <= '0;
			dst_value_q         <= '0;
			dst_mask_q          <= '0;
			modes_q             <= '0;
			counts_q            <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ETHERTYPE:   ethertype_value_q   <= cfg_data[15:0];
				REG_L4_PROTOCOL: l4_protocol_value_q <= cfg_data[7:0];
				REG_SRC_VALUE:   src_value_q         <= cfg_data;
				REG_SRC_MASK:    src_mask_q          <= cfg_data;
				REG_DST_VALUE:   dst_value_q         <= cfg_data;
				REG_DST_MASK:    dst_mask_q          <= cfg_data;
				REG_MODES:       modes_q             <= cfg_data[11:0];
				REG_COUNTS:      counts_q            <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// the pipeline moves as one; hold everything while the result waits
	assign advance   = !(valid_s3 && out_stall);
	assign in_stall  = !advance;
	assign in_accept = in_valid && advance;

	assign src_wr.en   = in_accept && operation == OP_WRITE_SRC
		&& 32'(entry_index) < PORT_ENTRIES;
	assign src_wr.idx  = entry_index;
	assign src_wr.port = entry_port;
	assign dst_wr.en   = in_accept && operation == OP_WRITE_DST
		&& 32'(entry_index) < PORT_ENTRIES;
	assign dst_wr.idx  = entry_index;
	assign dst_wr.port = entry_port;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: capture
	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1      <= operation;
			etype_s1   <= ethertype;
			sip_s1     <= source_ip;
			dip_s1     <= dest_ip;
			proto_s1   <= ip_protocol;
			tcp_udp_s1 <= is_tcp_or_udp;
			sport_s1   <= source_port;
			dport_s1   <= dest_port;
		end
	end

	// stage 2: raw matches
	always_ff @(posedge clk) begin
		if (advance) begin
			op_s2        <= op_s1;
			tcp_udp_s2   <= tcp_udp_s1;
			ipv4_s2      <= etype_s1 == IPV4_ETHERTYPE;
			l3_match_s2  <= etype_s1 == ethertype_value_q;
			src_match_s2 <= (sip_s1 & src_mask_q) == (src_value_q & src_mask_q);
			dst_match_s2 <= (dip_s1 & dst_mask_q) == (dst_value_q & dst_mask_q);
			l4_match_s2  <= proto_s1 == l4_protocol_value_q;
		end
	end

	ftpf_port_list u_sport_list (
		.clk      (clk),
		.wr       (src_wr),
		.advance  (advance),
		.port     (sport_s1),
		.count    (sat_count(counts_q[3:0])),
		.match_s2 (sport_match_s2)
	);

	ftpf_port_list u_dport_list (
		.clk      (clk),
		.wr       (dst_wr),
		.advance  (advance),
		.port     (dport_s1),
		.count    (sat_count(counts_q[7:4])),
		.match_s2 (dport_match_s2)
	);

	// stage 3: enable, negate and pick the first failure
	always_comb begin
		match_s2[COND_L3]    = l3_match_s2;
		match_s2[COND_SRC]   = src_match_s2;
		match_s2[COND_DST]   = dst_match_s2;
		match_s2[COND_L4]    = l4_match_s2;
		match_s2[COND_SPORT] = sport_match_s2;
		match_s2[COND_DPORT] = dport_match_s2;
		for (int k = 0; k < NUM_CONDS; k++) begin
			en[k]   = modes_q[2*k];
			neg[k]  = modes_q[2*k+1];
			fail[k] = en[k] && (match_s2[k] == neg[k]);
		end
	end

	always_comb begin
		priority if (op_s2 != OP_CLASSIFY) begin
			reason = REASON_TABLE;
		end else if (fail[COND_L3]) begin
			reason = REASON_L3;
		end else if (!ipv4_s2) begin
			reason = REASON_PASS;
		end else if (fail[COND_SRC]) begin
			reason = REASON_SRC;
		end else if (fail[COND_DST]) begin
			reason = REASON_DST;
		end else if (fail[COND_L4]) begin
			reason = REASON_L4;
		end else if (!tcp_udp_s2) begin
			reason = REASON_PASS;
		end else if (fail[COND_SPORT]) begin
			reason = REASON_SPORT;
		end else if (fail[COND_DPORT]) begin
			reason = REASON_DPORT;
		end else begin
			reason = REASON_PASS;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pass_s3   <= reason == REASON_PASS;
			reason_s3 <= reason;
		end
	end

	assign out_valid      = valid_s3;
	assign pass           = pass_s3;
	assign verdict_reason = reason_s3;

endmodule

>>> sv/ftpf_checker.sv
// ---------------------------------------------------------------------------
// Five-tuple packet filter checker
// Port-level properties of the filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "five_tuple_packet_filter_top_defines.svh"

module ftpf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  operation,
	input logic        out_valid,
	input logic        out_stall,
	input logic        pass,
	input logic [2:0]  verdict_reason
);
	import ftpf_pkg::*;

	// a waiting result holds
	`FTPF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pass) && $stable(verdict_reason))

	// pass and a zero reason always go together
	`FTPF_ASSERT_IMP(a_pass_reason, out_valid, pass == (verdict_reason == REASON_PASS))

	// input is held only by a blocked result
	`FTPF_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

	// a source table write comes out with a table verdict when the output does not stall
	`FTPF_ASSERT_NXT(a_write_latency, (in_valid && !in_stall && operation == OP_WRITE_SRC) ##1 !out_stall ##1 !out_stall, out_valid && !pass && verdict_reason == REASON_TABLE)

endmodule

bind five_tuple_packet_filter_top ftpf_checker u_ftpf_checker (.*);

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// Five-tuple packet filter testbench
// Drives classify and port table items through the filter under several
// register settings and traffic patterns. A scoreboard predicts each verdict
// and checks the results in order.
// ---------------------------------------------------------------------------
module tb_top;
	import ftpf_pkg::*;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BEYOND = 4'd9;
	localparam int NUM_REGS = 8;
	localparam int ENTRY_W = $clog2(PORT_ENTRIES);
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam int RESET_CYCLES = 11;
	localparam int NUM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int PRESSURE_HOLD = 80;
	localparam int DRAIN_GAP = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] ethertype;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [7:0]  ip_protocol;
		logic        is_tcp_or_udp;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [2:0]  entry_index;
		logic [15:0] entry_port;
	} filter_item_t;

	typedef struct packed {
		logic       pass;
		logic [2:0] reason;
	} verdict_t;

	class verdict_scoreboard;
		logic [15:0] eth_val;
		logic [7:0]  proto_val;
		logic [31:0] sa_val;
		logic [31:0] sa_mask;
		logic [31:0] da_val;
		logic [31:0] da_mask;
		logic [11:0] modes;
		logic [7:0]  counts;
		logic [15:0] src_ports [PORT_ENTRIES];
		logic [15:0] dst_ports [PORT_ENTRIES];
		verdict_t    expected_verdicts [$];
		int          errors;
		int          reports;

		function new();
			eth_val = '0;
			proto_val = '0;
			sa_val = '0;
			sa_mask = '0;
			da_val = '0;
			da_mask = '0;
			modes = '0;
			counts = '0;
			errors = 0;
			reports = 0;
			for (int i = 0; i < PORT_ENTRIES; i++) begin
				src_ports[ENTRY_W'(i)] = '0;
				dst_ports[ENTRY_W'(i)] = '0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				REG_ETHERTYPE: begin
					eth_val = data[15:0];
				end
				REG_L4_PROTOCOL: begin
					proto_val = data[7:0];
				end
				REG_SRC_VALUE: begin
					sa_val = data;
				end
				REG_SRC_MASK: begin
					sa_mask = data;
				end
				REG_DST_VALUE: begin
					da_val = data;
				end
				REG_DST_MASK: begin
					da_mask = data;
				end
				REG_MODES: begin
					modes = data[11:0];
				end
				REG_COUNTS: begin
					counts = data[7:0];
				end
				default: begin
				end
			endcase
		endfunction

		// an enabled condition fails when its match equals its negate bit
		function bit cond_fails(int k, bit hit);
			return modes[2*k] && (hit == modes[2*k+1]);
		endfunction

		function bit port_listed(bit dst, logic [3:0] raw, logic [15:0] port);
			int lim;
			lim = (int'(raw) > PORT_ENTRIES) ? PORT_ENTRIES : int'(raw);
			for (int i = 0; i < lim; i++) begin
				if ((dst ? dst_ports[ENTRY_W'(i)] : src_ports[ENTRY_W'(i)]) == port) begin
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function logic [2:0] predict_verdict(filter_item_t it);
			if (cond_fails(COND_L3, it.ethertype == eth_val)) begin
				return REASON_L3;
			end
			if (it.ethertype != IPV4_ETHERTYPE) begin
				return REASON_PASS;
			end
			if (cond_fails(COND_SRC, (it.source_ip & sa_mask) == (sa_val & sa_mask))) begin
				return REASON_SRC;
			end
			if (cond_fails(COND_DST, (it.dest_ip & da_mask) == (da_val & da_mask))) begin
				return REASON_DST;
			end
			if (cond_fails(COND_L4, it.ip_protocol == proto_val)) begin
				return REASON_L4;
			end
			if (!it.is_tcp_or_udp) begin
				return REASON_PASS;
			end
			if (cond_fails(COND_SPORT, port_listed(1'b0, counts[3:0], it.source_port))) begin
				return REASON_SPORT;
			end
			if (cond_fails(COND_DPORT, port_listed(1'b1, counts[7:4], it.dest_port))) begin
				return REASON_DPORT;
			end
			return REASON_PASS;
		endfunction

		function void note_item(filter_item_t it);
			verdict_t v;
			if (it.operation == OP_CLASSIFY) begin
				v.reason = predict_verdict(it);
				v.pass = (v.reason == REASON_PASS);
			end else begin
				if (it.operation == OP_WRITE_SRC && int'(it.entry_index) < PORT_ENTRIES) begin
					src_ports[it.entry_index] = it.entry_port;
				end else if (it.operation == OP_WRITE_DST
						&& int'(it.entry_index) < PORT_ENTRIES) begin
					dst_ports[it.entry_index] = it.entry_port;
				end
				v.pass = 1'b0;
				v.reason = REASON_TABLE;
			end
			expected_verdicts = {expected_verdicts, v};
		endfunction

		function void flag(string field, int want, int got);
			errors++;
			if (reports < MAX_REPORTS) begin
				reports++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_result(logic p, logic [2:0] r);
			verdict_t e;
			if (expected_verdicts.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("%0t: unexpected verdict, expected none, got pass=%0b reason=%0d",
						$time, p, r);
				end
				return;
			end
			e = expected_verdicts.pop_front();
			if (p !== e.pass) begin
				flag("pass", int'(e.pass), int'(p));
			end
			if (r !== e.reason) begin
				flag("verdict_reason", int'(e.reason), int'(r));
			end
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [15:0] ethertype;
	logic [31:0] source_ip;
	logic [31:0] dest_ip;
	logic [7:0]  ip_protocol;
	logic        is_tcp_or_udp;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [2:0]  entry_index;
	logic [15:0] entry_port;
	logic        out_valid;
	logic        out_stall;
	logic        pass;
	logic [2:0]  verdict_reason;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	verdict_scoreboard verdicts;
	logic [31:0] cfg_vals [2**CFG_IDX_W];
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	int quiet_cycles = 0;

	five_tuple_packet_filter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.ethertype(ethertype),
		.source_ip(source_ip),
		.dest_ip(dest_ip),
		.ip_protocol(ip_protocol),
		.is_tcp_or_udp(is_tcp_or_udp),
		.source_port(source_port),
		.dest_port(dest_port),
		.entry_index(entry_index),
		.entry_port(entry_port),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pass(pass),
		.verdict_reason(verdict_reason),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// receiver: random stalls, or one long hold-off when requested
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				out_stall <= ($urandom_range(99) < stall_pct);
				hold_len <= 0;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			verdicts.check_result(pass, verdict_reason);
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0)
				|| (out_valid === 1'b1 && out_stall === 1'b0)
				|| (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// hold the item until accepted; valid stays high for a following item
	task automatic send_item(filter_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= it.operation;
		ethertype <= it.ethertype;
		source_ip <= it.source_ip;
		dest_ip <= it.dest_ip;
		ip_protocol <= it.ip_protocol;
		is_tcp_or_udp <= it.is_tcp_or_udp;
		source_port <= it.source_port;
		dest_port <= it.dest_port;
		entry_index <= it.entry_index;
		entry_port <= it.entry_port;
		do @(posedge clk); while (in_stall !== 1'b0);
		verdicts.note_item(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (verdicts.pending() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		verdicts.set_reg(idx, data);
	endtask

	task automatic load_config(bit stray);
		for (int i = 0; i < NUM_REGS; i++) begin
			write_reg(CFG_IDX_W'(i), cfg_vals[CFG_IDX_W'(i)]);
		end
		// an index past the last register must change nothing
		if (stray) begin
			write_reg(REG_BEYOND, $urandom());
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic void pick_config(int kind);
		logic [11:0] m;
		int len;
		case (kind)
			0: begin
				for (int i = 0; i < NUM_REGS; i++) cfg_vals[CFG_IDX_W'(i)] = '1;
			end
			1: begin
				for (int i = 0; i < NUM_REGS; i++) cfg_vals[CFG_IDX_W'(i)] = '0;
			end
			default: begin
				cfg_vals[REG_ETHERTYPE] = $urandom_range(1) ? 32'(IPV4_ETHERTYPE) : $urandom();
				cfg_vals[REG_L4_PROTOCOL] = $urandom_range(1) ? 32'(PROTO_TCP) : $urandom();
				cfg_vals[REG_SRC_VALUE] = $urandom();
				len = $urandom_range(32);
				cfg_vals[REG_SRC_MASK] = ~(32'hFFFF_FFFF >> len);
				cfg_vals[REG_DST_VALUE] = $urandom();
				len = $urandom_range(32);
				cfg_vals[REG_DST_MASK] = ~(32'hFFFF_FFFF >> len);
				for (int k = 0; k < NUM_CONDS; k++) begin
					m[2*k] = ($urandom_range(3) != 0);
					m[2*k+1] = ($urandom_range(3) == 0);
				end
				cfg_vals[REG_MODES] = {20'h0, m};
				cfg_vals[REG_COUNTS] = $urandom_range(255);
			end
		endcase
	endfunction

	function automatic filter_item_t pkt_item(logic [15:0] et, logic [31:0] sip,
			logic [31:0] dip, logic [7:0] proto, logic tu, logic [15:0] sp, logic [15:0] dp);
		filter_item_t it;
		it.operation = OP_CLASSIFY;
		it.ethertype = et;
		it.source_ip = sip;
		it.dest_ip = dip;
		it.ip_protocol = proto;
		it.is_tcp_or_udp = tu;
		it.source_port = sp;
		it.dest_port = dp;
		it.entry_index = 3'($urandom());
		it.entry_port = 16'($urandom());
		return it;
	endfunction

	function automatic filter_item_t tbl_item(logic [1:0] op, logic [2:0] idx,
			logic [15:0] port);
		filter_item_t it;
		it = pkt_item(16'($urandom()), $urandom(), $urandom(), 8'($urandom()),
			1'($urandom()), 16'($urandom()), 16'($urandom()));
		it.operation = op;
		it.entry_index = idx;
		it.entry_port = port;
		return it;
	endfunction

	// mostly packets that get deep into the checks, some table writes and noise
	function automatic filter_item_t rand_item();
		filter_item_t it;
		int r;
		it = tbl_item(OP_CLASSIFY, 3'($urandom()), 16'($urandom()));
		r = $urandom_range(99);
		if (r < 8) begin
			it.operation = r[0] ? OP_WRITE_SRC : OP_WRITE_DST;
		end else if (r < 10) begin
			it.operation = OP_NONE;
		end else begin
			r = $urandom_range(9);
			if (r < 7) begin
				it.ethertype = IPV4_ETHERTYPE;
			end else if (r < 8) begin
				it.ethertype = verdicts.eth_val;
			end
			if ($urandom_range(9) < 6) begin
				it.source_ip = (verdicts.sa_val & verdicts.sa_mask)
					| (it.source_ip & ~verdicts.sa_mask);
			end
			if ($urandom_range(9) < 6) begin
				it.dest_ip = (verdicts.da_val & verdicts.da_mask)
					| (it.dest_ip & ~verdicts.da_mask);
			end
			if ($urandom_range(1)) begin
				it.ip_protocol = verdicts.proto_val;
			end
			it.is_tcp_or_udp = ($urandom_range(3) != 0);
			if ($urandom_range(9) < 6) begin
				it.source_port = verdicts.src_ports[ENTRY_W'($urandom_range(PORT_ENTRIES-1))];
			end
			if ($urandom_range(9) < 6) begin
				it.dest_port = verdicts.dst_ports[ENTRY_W'($urandom_range(PORT_ENTRIES-1))];
			end
		end
		return it;
	endfunction

	initial begin
		logic [31:0] sip_in;
		logic [31:0] dip_in;
		sip_in = 32'h0A12_3456;
		dip_in = 32'hC0A8_BEEF;
		verdicts = new();
		arst_n = 1'b0;
		in_valid <= 1'b0;
		operation <= OP_CLASSIFY;
		ethertype <= '0;
		source_ip <= '0;
		dest_ip <= '0;
		ip_protocol <= '0;
		is_tcp_or_udp <= 1'b0;
		source_port <= '0;
		dest_port <= '0;
		entry_index <= '0;
		entry_port <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both port tables so no unwritten entry is ever read
		for (int i = 0; i < PORT_ENTRIES; i++) begin
			send_item(tbl_item(OP_WRITE_SRC, ENTRY_W'(i),
				(i == 0) ? 16'h0000 : (i == PORT_ENTRIES - 1) ? 16'hFFFF : 16'($urandom())));
		end
		for (int i = 0; i < PORT_ENTRIES; i++) begin
			send_item(tbl_item(OP_WRITE_DST, ENTRY_W'(i),
				(i == 0) ? 16'hFFFF : (i == PORT_ENTRIES - 1) ? 16'h0000 : 16'($urandom())));
		end
		drain();

		cfg_vals[REG_ETHERTYPE] = 32'(IPV4_ETHERTYPE);
		cfg_vals[REG_L4_PROTOCOL] = 32'(PROTO_TCP);
		cfg_vals[REG_SRC_VALUE] = 32'h0A00_0000;
		cfg_vals[REG_SRC_MASK] = 32'hFF00_0000;
		cfg_vals[REG_DST_VALUE] = 32'hC0A8_0000;
		cfg_vals[REG_DST_MASK] = 32'hFFFF_0000;
		cfg_vals[REG_MODES] = 32'h555;
		cfg_vals[REG_COUNTS] = 32'h88;
		load_config(1'b0);
		send_item(pkt_item(IPV4_ETHERTYPE, sip_in, dip_in, PROTO_TCP, 1'b1, 16'h0000, 16'h0000));
		send_item(pkt_item(16'h0000, sip_in, dip_in, PROTO_TCP, 1'b1, 16'h0000, 16'h0000));
		send_item(pkt_item(16'hFFFF, sip_in, dip_in, PROTO_TCP, 1'b1, 16'h0000, 16'h0000));
		send_item(pkt_item(IPV4_ETHERTYPE, 32'hFFFF_FFFF, dip_in, PROTO_TCP, 1'b1,
			16'h0000, 16'h0000));
		send_item(pkt_item(IPV4_ETHERTYPE, sip_in, 32'h0000_0000, PROTO_TCP, 1'b1,
			16'h0000, 16'h0000));
		send_item(pkt_item(IPV4_ETHERTYPE, sip_in, dip_in, 8'hFF, 1'b1, 16'h0000, 16'h0000));
		send_item(pkt_item(IPV4_ETHERTYPE, sip_in, dip_in, PROTO_TCP, 1'b0,
			16'($urandom()), 16'($urandom())));
		send_item(pkt_item(IPV4_ETHERTYPE, sip_in, dip_in, PROTO_TCP, 1'b1, 16'h1234, 16'hFFFF));
		send_item(pkt_item(IPV4_ETHERTYPE, sip_in, dip_in, PROTO_TCP, 1'b1, 16'hFFFF, 16'h1234));
		send_item(tbl_item(OP_NONE, 3'($urandom()), 16'($urandom())));
		drain();

		// everything negated, destination list empty, source count saturates
		cfg_vals[REG_ETHERTYPE] = 32'h86DD;
		cfg_vals[REG_MODES] = 32'hFFF;
		cfg_vals[REG_COUNTS] = 32'h0F;
		load_config(1'b0);
		send_item(pkt_item(16'h86DD, sip_in, dip_in, PROTO_TCP, 1'b1, 16'h0000, 16'h0000));
		send_item(pkt_item(16'h0806, sip_in, dip_in, PROTO_TCP, 1'b1, 16'h0000, 16'h0000));
		send_item(pkt_item(IPV4_ETHERTYPE, sip_in, dip_in, PROTO_TCP, 1'b1, 16'h0000, 16'h0000));
		drain();

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			pick_config(phase);
			load_config(phase == 2);
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 87;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 87;
				end
				default: begin
					idle_pct = 10;
					stall_pct = 10;
				end
			endcase
			// back up the pipeline while items keep coming
			if (phase == 0) begin
				hold_len <= PRESSURE_HOLD;
			end
			repeat (ITEMS_PER_PHASE) send_item(rand_item());
			drain();
		end

		if (verdicts.errors == 0 && verdicts.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
